>>> rtl/core/rcag_pkg.sv
package rcag_pkg;

  localparam int ADDR_W   = 8;
  localparam int RUN_W    = 8;
  localparam int MASK_W   = 16;
  localparam int TIME_W   = 32;
  localparam int QUAL_W   = 8;
  localparam int DROP_W   = 32;
  localparam int REASON_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic [REASON_W-1:0] reason_t;

  // Result reason codes
  localparam reason_t REASON_NONE        = 3'd0;
  localparam reason_t REASON_QUALIFYING  = 3'd1;
  localparam reason_t REASON_UNCONFIG    = 3'd2;
  localparam reason_t REASON_BAD_ADDR    = 3'd3;
  localparam reason_t REASON_MISSING_CH  = 3'd4;
  localparam reason_t REASON_RC_STALE    = 3'd5;
  localparam reason_t REASON_STATS_STALE = 3'd6;
  localparam reason_t REASON_QUALITY_0   = 3'd7;

  // Operation codes
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_ENABLE      = 3'd0;
  localparam cfg_idx_t REG_ADDRESS     = 3'd1;
  localparam cfg_idx_t REG_FRAMES      = 3'd2;
  localparam cfg_idx_t REG_CHAN_MASK   = 3'd3;
  localparam cfg_idx_t REG_FRAME_LIMIT = 3'd4;
  localparam cfg_idx_t REG_STATS_LIMIT = 3'd5;

endpackage

>>> rtl/core/rc_receiver_admission_gate.sv
// Latency: a result beat appears on the cycle after its request beat is taken.
// Throughput: one request beat per clock; req_ready drops only while a
// finished result waits in the output register and rsp_ready is low.
// Reset (rst, synchronous, active high) clears all settings and state:
// not qualified, run 0, drops 0, reason "unconfigured", no result pending.
module rc_receiver_admission_gate (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [rcag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcag_pkg::CFG_DATA_W-1:0]   cfg_data,
  // request channel
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic                              operation,
  input  logic [rcag_pkg::TIME_W-1:0]       time_ms,
  input  logic [rcag_pkg::ADDR_W-1:0]       frame_address,
  input  logic [rcag_pkg::MASK_W-1:0]       valid_channels,
  input  logic                              stats_present,
  input  logic [rcag_pkg::QUAL_W-1:0]       quality,
  input  logic [rcag_pkg::TIME_W-1:0]       stats_age_ms,
  // result channel
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic                              ok,
  output logic                              qualified,
  output logic [rcag_pkg::RUN_W-1:0]        frame_run,
  output logic [rcag_pkg::REASON_W-1:0]     reason,
  output logic [rcag_pkg::DROP_W-1:0]       drops
);
  import rcag_pkg::*;

  // Settings
  logic              admission_enable;
  logic [ADDR_W-1:0] expected_address;
  logic [RUN_W-1:0]  frames_needed;
  logic [MASK_W-1:0] channel_mask_needed;
  logic [TIME_W-1:0] frame_fresh_limit_ms;
  logic [TIME_W-1:0] stats_fresh_limit_ms;
  logic              configured;   // all settings valid, kept registered

  logic              admission_enable_next;
  logic [ADDR_W-1:0] expected_address_next;
  logic [RUN_W-1:0]  frames_needed_next;
  logic [MASK_W-1:0] channel_mask_needed_next;
  logic [TIME_W-1:0] frame_fresh_limit_ms_next;
  logic [TIME_W-1:0] stats_fresh_limit_ms_next;
  logic              configured_next;
  logic              cfg_hit;

  // Admission state
  logic              is_qualified, is_qualified_next;
  logic [RUN_W-1:0]  run_count, run_count_next;
  reason_t           last_reason, last_reason_next;
  logic [DROP_W-1:0] drop_count, drop_count_next;
  logic              frame_seen, frame_seen_next;
  logic [TIME_W-1:0] last_frame_time, last_frame_time_next;
  logic              ok_next;

  logic              accept;
  logic [TIME_W-1:0] gap;
  logic              stale;
  logic [DROP_W-1:0] drop_sat;

  // Output register parts the two sides: a new beat is taken whenever the
  // held result is gone or leaves this cycle.
  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  // ---------------------------------------------------------------------
  // Settings write decode. Any write to a real register clears the state;
  // the new reason depends on the settings after the write.
  // ---------------------------------------------------------------------
  always_comb begin
    admission_enable_next     = admission_enable;
    expected_address_next     = expected_address;
    frames_needed_next        = frames_needed;
    channel_mask_needed_next  = channel_mask_needed;
    frame_fresh_limit_ms_next = frame_fresh_limit_ms;
    stats_fresh_limit_ms_next = stats_fresh_limit_ms;
    cfg_hit                   = 1'b0;
    if (cfg_we) begin
      cfg_hit = 1'b1;
      unique case (cfg_index)
        REG_ENABLE:      admission_enable_next     = cfg_data[0];
        REG_ADDRESS:     expected_address_next     = cfg_data[ADDR_W-1:0];
        REG_FRAMES:      frames_needed_next        = cfg_data[RUN_W-1:0];
        REG_CHAN_MASK:   channel_mask_needed_next  = cfg_data[MASK_W-1:0];
        REG_FRAME_LIMIT: frame_fresh_limit_ms_next = cfg_data[TIME_W-1:0];
        REG_STATS_LIMIT: stats_fresh_limit_ms_next = cfg_data[TIME_W-1:0];
        default:         cfg_hit = 1'b0;   // indexes past the list: ignored
      endcase
    end
    configured_next = admission_enable_next &&
                      (expected_address_next != '0) &&
                      (frames_needed_next != '0) &&
                      (channel_mask_needed_next != '0) &&
                      (frame_fresh_limit_ms_next != '0) &&
                      (stats_fresh_limit_ms_next != '0);
  end

  // ---------------------------------------------------------------------
  // Single-pass step logic for one request beat.
  // ---------------------------------------------------------------------
  // Gap wraps mod 2^32; with no frame seen the link is always stale.
  assign gap      = time_ms - last_frame_time;
  assign stale    = !frame_seen || (gap > frame_fresh_limit_ms);
  assign drop_sat = (drop_count == '1) ? drop_count : drop_count + 1'b1;

  always_comb begin
    is_qualified_next    = is_qualified;
    run_count_next       = run_count;
    last_reason_next     = last_reason;
    drop_count_next      = drop_count;
    frame_seen_next      = frame_seen;
    last_frame_time_next = last_frame_time;
    ok_next              = 1'b0;

    unique case (operation)
      OP_FRAME: begin
        if (!configured || (frame_address != expected_address) ||
            ((valid_channels & channel_mask_needed) != channel_mask_needed)) begin
          // Rejection: checks in order configured, address, channels
          is_qualified_next    = 1'b0;
          run_count_next       = '0;
          drop_count_next      = drop_sat;
          frame_seen_next      = 1'b0;
          last_frame_time_next = '0;
          if (!configured) begin
            last_reason_next = REASON_UNCONFIG;
          end else if (frame_address != expected_address) begin
            last_reason_next = REASON_BAD_ADDR;
          end else begin
            last_reason_next = REASON_MISSING_CH;
          end
        end else begin
          // Good frame: restart run when stale, else count up to the target
          if (stale) begin
            run_count_next = RUN_W'(1);
          end else if (run_count < frames_needed) begin
            run_count_next = run_count + 1'b1;
          end
          frame_seen_next      = 1'b1;
          last_frame_time_next = time_ms;
          is_qualified_next    = (run_count_next >= frames_needed);
          last_reason_next     = is_qualified_next ? REASON_NONE : REASON_QUALIFYING;
          ok_next              = is_qualified_next;
        end
      end
      OP_QUERY: begin
        if (!configured) begin
          last_reason_next = REASON_UNCONFIG;
        end else if (stale) begin
          // drops and frame_seen are kept on a stale query
          is_qualified_next = 1'b0;
          run_count_next    = '0;
          last_reason_next  = REASON_RC_STALE;
        end else if (is_qualified) begin
          if (stats_present && (stats_age_ms > stats_fresh_limit_ms)) begin
            last_reason_next = REASON_STATS_STALE;
          end else if (stats_present && (quality == '0)) begin
            last_reason_next = REASON_QUALITY_0;
          end else begin
            last_reason_next = REASON_NONE;
            ok_next          = 1'b1;
          end
        end
        // fresh but not qualified: nothing changes
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      admission_enable     <= 1'b0;
      expected_address     <= '0;
      frames_needed        <= '0;
      channel_mask_needed  <= '0;
      frame_fresh_limit_ms <= '0;
      stats_fresh_limit_ms <= '0;
      configured           <= 1'b0;
      is_qualified         <= 1'b0;
      run_count            <= '0;
      last_reason          <= REASON_UNCONFIG;
      drop_count           <= '0;
      frame_seen           <= 1'b0;
      last_frame_time      <= '0;
      rsp_valid            <= 1'b0;
    end else begin
      admission_enable     <= admission_enable_next;
      expected_address     <= expected_address_next;
      frames_needed        <= frames_needed_next;
      channel_mask_needed  <= channel_mask_needed_next;
      frame_fresh_limit_ms <= frame_fresh_limit_ms_next;
      stats_fresh_limit_ms <= stats_fresh_limit_ms_next;
      configured           <= configured_next;

      if (cfg_hit) begin
        // Settings change wipes the run and the drop count
        is_qualified    <= 1'b0;
        run_count       <= '0;
        drop_count      <= '0;
        frame_seen      <= 1'b0;
        last_frame_time <= '0;
        last_reason     <= configured_next ? REASON_QUALIFYING : REASON_UNCONFIG;
      end else if (accept) begin
        is_qualified    <= is_qualified_next;
        run_count       <= run_count_next;
        last_reason     <= last_reason_next;
        drop_count      <= drop_count_next;
        frame_seen      <= frame_seen_next;
        last_frame_time <= last_frame_time_next;
      end

      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result payload: snapshot of the state after the step
  always_ff @(posedge clk) begin
    if (accept) begin
      ok        <= ok_next;
      qualified <= is_qualified_next;
      frame_run <= run_count_next;
      reason    <= last_reason_next;
      drops     <= drop_count_next;
    end
  end

endmodule
